>>> design/dcpu_pkg.sv
// ---------------------------------------------------------------------------
// dcpu_pkg: shared types and constants for the 16-bit CPU step block
// Item kinds, opcodes, operand codes and the memory request and divider
// status structs.
// ---------------------------------------------------------------------------
package dcpu_pkg;

	localparam int MEM_WORDS_DEF = 65536;

	localparam logic [1:0] K_EXEC  = 2'd0;
	localparam logic [1:0] K_WRITE = 2'd1;
	localparam logic [1:0] K_READ  = 2'd2;
	localparam logic [1:0] K_REG   = 2'd3;

	localparam logic [3:0] OP_NB  = 4'h0;
	localparam logic [3:0] OP_SET = 4'h1;
	localparam logic [3:0] OP_ADD = 4'h2;
	localparam logic [3:0] OP_SUB = 4'h3;
	localparam logic [3:0] OP_MUL = 4'h4;
	localparam logic [3:0] OP_DIV = 4'h5;
	localparam logic [3:0] OP_MOD = 4'h6;
	localparam logic [3:0] OP_SHL = 4'h7;
	localparam logic [3:0] OP_SHR = 4'h8;
	localparam logic [3:0] OP_AND = 4'h9;
	localparam logic [3:0] OP_BOR = 4'hA;
	localparam logic [3:0] OP_XOR = 4'hB;
	localparam logic [3:0] OP_IFE = 4'hC;
	localparam logic [3:0] OP_IFN = 4'hD;
	localparam logic [3:0] OP_IFG = 4'hE;
	localparam logic [3:0] OP_IFB = 4'hF;

	localparam logic [5:0] NB_JSR    = 6'h01;
	localparam logic [5:0] CODE_POP  = 6'h18;
	localparam logic [5:0] CODE_PEEK = 6'h19;
	localparam logic [5:0] CODE_PUSH = 6'h1A;
	localparam logic [5:0] CODE_SP   = 6'h1B;
	localparam logic [5:0] CODE_PC   = 6'h1C;
	localparam logic [5:0] CODE_O    = 6'h1D;
	localparam logic [5:0] CODE_NWI  = 6'h1E;
	localparam logic [5:0] CODE_NWL  = 6'h1F;

	localparam logic [15:0] REG_PC = 16'd8;
	localparam logic [15:0] REG_SP = 16'd9;
	localparam logic [15:0] REG_O  = 16'd10;

	localparam logic [2:0] LOC_REG = 3'd0;
	localparam logic [2:0] LOC_MEM = 3'd1;
	localparam logic [2:0] LOC_SP  = 3'd2;
	localparam logic [2:0] LOC_PC  = 3'd3;
	localparam logic [2:0] LOC_O   = 3'd4;
	localparam logic [2:0] LOC_LIT = 3'd5;

	typedef struct packed {
		logic        en;
		logic        we;
		logic [15:0] addr;
		logic [15:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic extra_word(input logic [5:0] code);
		return (code[5:3] == 3'b010) || (code == CODE_NWI) || (code == CODE_NWL);
	endfunction

endpackage

>>> design/dcpu_req_if.sv
// ---------------------------------------------------------------------------
// dcpu_req_if: request channel
// Valid/ready channel carrying one request item.
// ---------------------------------------------------------------------------
interface dcpu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [15:0] write_data;

	modport source(output valid, kind, address, write_data, input ready);
	modport sink(input valid, kind, address, write_data, output ready);
endinterface

>>> design/dcpu_rsp_if.sv
// ---------------------------------------------------------------------------
// dcpu_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface dcpu_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic [15:0] pc_after;
	logic        fault;

	modport source(output valid, read_data, pc_after, fault, input ready);
	modport sink(input valid, read_data, pc_after, fault, output ready);
endinterface

>>> design/sixteen_bit_cpu_step_top.sv
// ---------------------------------------------------------------------------
// sixteen_bit_cpu_step_top: 16-bit CPU step engine
// Executes one instruction, or loads or reads a memory word or a register,
// per request.
// ---------------------------------------------------------------------------
// Each request yields one response. Register reads and memory writes are
// answered straight from the accept state, memory reads pass through a read
// state, and a reserved opcode ends in the decode state with a fault. Any other
// instruction passes through the fetch, the decode, a state per register or
// short-literal operand, one more for each next word and one more for each
// memory operand read, the execute or write-back state, a state to decode a
// skipped instruction and the response. DIV and MOD with a nonzero divisor
// also wait on the bit-serial divider. Memory contents are undefined until
// written; addresses below 64 * MEM_WORDS wrap at MEM_WORDS. A new request
// is taken once the previous response is accepted.
module sixteen_bit_cpu_step_top
	import dcpu_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dcpu_req_if.sink   req,
	dcpu_rsp_if.source rsp
);
	mem_req_t    mreq;
	logic [15:0] mrdata;
	logic        div_start;
	logic [15:0] div_a, div_b;
	logic [31:0] div_quot;
	logic [15:0] div_rem;
	div_stat_t   div_stat;

	dcpu_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (mrdata)
	);

	dcpu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.quot   (div_quot),
		.rem    (div_rem),
		.stat   (div_stat)
	);

	dcpu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mreq      (mreq),
		.mrdata    (mrdata),
		.div_start (div_start),
		.div_a     (div_a),
		.div_b     (div_b),
		.div_quot  (div_quot),
		.div_rem   (div_rem),
		.div_stat  (div_stat)
	);
endmodule

>>> design/dcpu_mem.sv
// ---------------------------------------------------------------------------
// dcpu_mem: main word memory
// Single-port synchronous RAM, registered read data, address folded into
// the memory depth.
// ---------------------------------------------------------------------------
module dcpu_mem
	import dcpu_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic        clk,
	input  mem_req_t    req,
	output logic [15:0] rdata
);
	localparam int AW = $clog2(MEM_WORDS);

	logic [15:0] mem [MEM_WORDS];
	logic [AW-1:0] idx;

	function automatic logic [AW-1:0] fold(input logic [15:0] a);
		logic [15:0] r;
		r = a;
		for (int k = 5; k >= 0; k--) begin
			if (32'(r) >= (32'(MEM_WORDS) << k)) begin
				r = r - 16'((32'(MEM_WORDS) << k));
			end
		end
		return r[AW-1:0];
	endfunction

	assign idx = fold(req.addr);

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[idx] <= req.wdata;
			end
			rdata <= mem[idx];
		end
	end
endmodule

>>> design/dcpu_div.sv
// ---------------------------------------------------------------------------
// dcpu_div: shared radix-2 divider
// Divides {a, 16'h0} by b one bit a cycle; the remainder after the upper
// sixteen steps is a mod b.
// ---------------------------------------------------------------------------
module dcpu_div
	import dcpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [31:0] quot,
	output logic [15:0] rem,
	output div_stat_t   stat
);
	logic [15:0] r_q;
	logic [31:0] d_q;
	logic [15:0] m_q;
	logic [15:0] b_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rs;
	logic        ge;
	logic [15:0] rn;

	assign rs = {r_q, d_q[31]};
	assign ge = rs >= {1'b0, b_q};
	assign rn = ge ? 16'(rs - {1'b0, b_q}) : rs[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			d_q    <= '0;
			m_q    <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				r_q    <= '0;
				d_q    <= {a, 16'h0000};
				b_q    <= b;
			end else if (busy_q) begin
				r_q   <= rn;
				d_q   <= {d_q[30:0], ge};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd17) begin
					m_q <= rn;
				end
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot = d_q;
	assign rem  = m_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

>>> design/dcpu_core.sv
// ---------------------------------------------------------------------------
// dcpu_core: instruction sequencer
// Fetches, resolves operands, runs the ALU and writes back through the
// single memory port, one access per cycle.
// ---------------------------------------------------------------------------
module dcpu_core
	import dcpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	dcpu_req_if.sink    req,
	dcpu_rsp_if.source  rsp,
	output mem_req_t    mreq,
	input  logic [15:0] mrdata,
	output logic        div_start,
	output logic [15:0] div_a,
	output logic [15:0] div_b,
	input  logic [31:0] div_quot,
	input  logic [15:0] div_rem,
	input  div_stat_t   div_stat
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MRD  = 4'd1;
	localparam logic [3:0] S_INS  = 4'd2;
	localparam logic [3:0] S_OPND = 4'd3;
	localparam logic [3:0] S_NW   = 4'd4;
	localparam logic [3:0] S_OPRD = 4'd5;
	localparam logic [3:0] S_EXEC = 4'd6;
	localparam logic [3:0] S_DIVW = 4'd7;
	localparam logic [3:0] S_SKIP = 4'd8;

	logic [3:0]  state_q;
	logic [15:0] gr_q [8];
	logic [15:0] pc_q, sp_q, o_q;
	logic [15:0] ins_q, a_q, b_q, la_val_q, rd_q;
	logic [2:0]  la_kind_q;
	logic        slot_q, out_valid_q, fault_q;
	logic [1:0]  kind_q;

	logic        fire;
	logic [3:0]  op;
	logic        jsr;
	logic [5:0]  code;
	logic [15:0] nw_addr;
	logic [15:0] res, o_new;
	logic        o_set, wb, skip, need_div, wb_fire;
	logic [16:0] sum;
	logic [31:0] prod;
	logic [47:0] shl_t;
	logic [31:0] shr_t;
	logic        big;
	logic [15:0] reg_rd;
	logic [15:0] skip_n;

	assign fire      = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign op        = ins_q[3:0];
	assign jsr       = (op == OP_NB);
	assign code      = (slot_q || jsr) ? ins_q[15:10] : ins_q[9:4];
	assign nw_addr   = (code == CODE_NWI) ? mrdata : 16'(gr_q[code[2:0]] + mrdata);

	always_comb begin
		sum   = {1'b0, a_q} + {1'b0, b_q};
		prod  = a_q * b_q;
		shl_t = {32'h0, a_q} << b_q[4:0];
		shr_t = {a_q, 16'h0000} >> b_q[4:0];
		big   = |b_q[15:5];
		res   = '0;
		o_new = '0;
		o_set = 1'b0;
		wb    = 1'b1;
		skip  = 1'b0;
		need_div = 1'b0;
		case (op)
			OP_SET: res = b_q;
			OP_ADD: begin
				res = sum[15:0]; o_set = 1'b1; o_new = {15'h0, sum[16]};
			end
			OP_SUB: begin
				res = 16'(a_q - b_q); o_set = 1'b1; o_new = (b_q > a_q) ? 16'hFFFF : 16'h0;
			end
			OP_MUL: begin
				res = prod[15:0]; o_set = 1'b1; o_new = prod[31:16];
			end
			OP_DIV: begin
				o_set = 1'b1;
				need_div = (b_q != 16'h0);
				res   = need_div ? div_quot[31:16] : 16'h0;
				o_new = need_div ? div_quot[15:0] : 16'h0;
			end
			OP_MOD: begin
				need_div = (b_q != 16'h0);
				res = need_div ? div_rem : 16'h0;
			end
			OP_SHL: begin
				o_set = 1'b1;
				res   = big ? 16'h0 : shl_t[15:0];
				o_new = big ? 16'h0 : shl_t[31:16];
			end
			OP_SHR: begin
				o_set = 1'b1;
				res   = big ? 16'h0 : shr_t[31:16];
				o_new = big ? 16'h0 : shr_t[15:0];
			end
			OP_AND: res = a_q & b_q;
			OP_BOR: res = a_q | b_q;
			OP_XOR: res = a_q ^ b_q;
			OP_IFE: begin wb = 1'b0; skip = (a_q != b_q); end
			OP_IFN: begin wb = 1'b0; skip = (a_q == b_q); end
			OP_IFG: begin wb = 1'b0; skip = (a_q <= b_q); end
			OP_IFB: begin wb = 1'b0; skip = ((a_q & b_q) == 16'h0); end
			default: wb = 1'b0;
		endcase
	end

	assign div_start = (state_q == S_EXEC) && !jsr && need_div;
	assign div_a     = a_q;
	assign div_b     = b_q;
	assign wb_fire   = ((state_q == S_EXEC) && !jsr && !need_div && wb)
		|| ((state_q == S_DIVW) && div_stat.done);

	always_comb begin
		if (req.address < 16'd8) begin
			reg_rd = gr_q[req.address[2:0]];
		end else if (req.address == REG_PC) begin
			reg_rd = pc_q;
		end else if (req.address == REG_SP) begin
			reg_rd = sp_q;
		end else if (req.address == REG_O) begin
			reg_rd = o_q;
		end else begin
			reg_rd = '0;
		end
	end

	assign skip_n = 16'({15'h0, extra_word(mrdata[15:10])}
		+ {15'h0, (mrdata[3:0] != OP_NB) && extra_word(mrdata[9:4])});

	always_comb begin
		mreq = '{en: 1'b0, we: 1'b0, addr: pc_q, wdata: req.write_data};
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					mreq.en   = (req.kind != K_REG);
					mreq.we   = (req.kind == K_WRITE);
					mreq.addr = (req.kind == K_EXEC) ? pc_q : req.address;
				end
			end
			S_OPND: begin
				if (extra_word(code)) begin
					mreq.en = 1'b1;
				end else if (code[5:3] == 3'b001) begin
					mreq.en = 1'b1; mreq.addr = gr_q[code[2:0]];
				end else if (code == CODE_POP || code == CODE_PEEK) begin
					mreq.en = 1'b1; mreq.addr = sp_q;
				end else if (code == CODE_PUSH) begin
					mreq.en = 1'b1; mreq.addr = 16'(sp_q - 16'd1);
				end
			end
			S_NW: begin
				if (code != CODE_NWL) begin
					mreq.en = 1'b1; mreq.addr = nw_addr;
				end
			end
			S_EXEC, S_DIVW: begin
				if (state_q == S_EXEC && jsr) begin
					mreq.en = 1'b1; mreq.we = 1'b1;
					mreq.addr = 16'(sp_q - 16'd1); mreq.wdata = pc_q;
				end else if (wb_fire && la_kind_q == LOC_MEM) begin
					mreq.en = 1'b1; mreq.we = 1'b1;
					mreq.addr = la_val_q; mreq.wdata = res;
				end else if (state_q == S_EXEC && skip) begin
					mreq.en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < 8; i++) begin
				gr_q[i] <= '0;
			end
			pc_q        <= '0;
			sp_q        <= '0;
			o_q         <= '0;
			out_valid_q <= 1'b0;
			fault_q     <= 1'b0;
			rd_q        <= '0;
			ins_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			la_val_q    <= '0;
			la_kind_q   <= LOC_LIT;
			slot_q      <= 1'b0;
			kind_q      <= K_EXEC;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						kind_q  <= req.kind;
						rd_q    <= '0;
						fault_q <= 1'b0;
						case (req.kind)
							K_EXEC: begin
								pc_q    <= 16'(pc_q + 16'd1);
								state_q <= S_INS;
							end
							K_READ:  state_q <= S_MRD;
							K_REG: begin
								rd_q        <= reg_rd;
								out_valid_q <= 1'b1;
							end
							default: out_valid_q <= 1'b1;
						endcase
					end
				end
				S_MRD: begin
					rd_q        <= mrdata;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_INS: begin
					ins_q  <= mrdata;
					slot_q <= 1'b0;
					if (mrdata[3:0] == OP_NB && mrdata[9:4] != NB_JSR) begin
						pc_q        <= 16'(pc_q + {15'h0, extra_word(mrdata[15:10])});
						fault_q     <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_OPND;
					end
				end
				S_OPND: begin
					if (extra_word(code)) begin
						pc_q    <= 16'(pc_q + 16'd1);
						state_q <= S_NW;
					end else if (code[5:3] == 3'b000 || code[5] || code == CODE_SP
						|| code == CODE_PC || code == CODE_O) begin
						if (!slot_q) begin
							la_val_q <= {13'h0, code[2:0]};
							if (code[5:3] == 3'b000) begin
								la_kind_q <= LOC_REG;
							end else if (code == CODE_SP) begin
								la_kind_q <= LOC_SP;
							end else if (code == CODE_PC) begin
								la_kind_q <= LOC_PC;
							end else if (code == CODE_O) begin
								la_kind_q <= LOC_O;
							end else begin
								la_kind_q <= LOC_LIT;
							end
						end
						if (code[5:3] == 3'b000) begin
							if (slot_q) b_q <= gr_q[code[2:0]]; else a_q <= gr_q[code[2:0]];
						end else if (code == CODE_SP) begin
							if (slot_q) b_q <= sp_q; else a_q <= sp_q;
						end else if (code == CODE_PC) begin
							if (slot_q) b_q <= pc_q; else a_q <= pc_q;
						end else if (code == CODE_O) begin
							if (slot_q) b_q <= o_q; else a_q <= o_q;
						end else begin
							if (slot_q) b_q <= {11'h0, code[4:0]};
							else a_q <= {11'h0, code[4:0]};
						end
						if (slot_q || jsr) begin
							state_q <= S_EXEC;
						end else begin
							slot_q <= 1'b1;
						end
					end else begin
						if (!slot_q) begin
							la_kind_q <= LOC_MEM;
							la_val_q  <= mreq.addr;
						end
						if (code == CODE_POP) begin
							sp_q <= 16'(sp_q + 16'd1);
						end else if (code == CODE_PUSH) begin
							sp_q <= 16'(sp_q - 16'd1);
						end
						state_q <= S_OPRD;
					end
				end
				S_NW: begin
					if (code == CODE_NWL) begin
						if (!slot_q) begin
							la_kind_q <= LOC_LIT;
							la_val_q  <= mrdata;
						end
						if (slot_q) b_q <= mrdata; else a_q <= mrdata;
						if (slot_q || jsr) begin
							state_q <= S_EXEC;
						end else begin
							slot_q  <= 1'b1;
							state_q <= S_OPND;
						end
					end else begin
						if (!slot_q) begin
							la_kind_q <= LOC_MEM;
							la_val_q  <= nw_addr;
						end
						state_q <= S_OPRD;
					end
				end
				S_OPRD: begin
					if (slot_q) b_q <= mrdata; else a_q <= mrdata;
					if (slot_q || jsr) begin
						state_q <= S_EXEC;
					end else begin
						slot_q  <= 1'b1;
						state_q <= S_OPND;
					end
				end
				S_EXEC, S_DIVW: begin
					if (state_q == S_EXEC && jsr) begin
						sp_q        <= 16'(sp_q - 16'd1);
						pc_q        <= a_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (state_q == S_EXEC && need_div) begin
						state_q <= S_DIVW;
					end else if (state_q == S_EXEC && skip) begin
						pc_q    <= 16'(pc_q + 16'd1);
						state_q <= S_SKIP;
					end else if (state_q == S_EXEC || div_stat.done) begin
						if (o_set || (wb_fire && la_kind_q == LOC_O)) begin
							o_q <= (wb_fire && la_kind_q == LOC_O) ? res : o_new;
						end
						if (wb_fire) begin
							case (la_kind_q)
								LOC_REG: gr_q[la_val_q[2:0]] <= res;
								LOC_SP:  sp_q <= res;
								LOC_PC:  pc_q <= res;
								default: ;
							endcase
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SKIP: begin
					pc_q        <= 16'(pc_q + skip_n);
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = rd_q;
	assign rsp.pc_after  = pc_q;
	assign rsp.fault     = fault_q;

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVW) |-> (div_stat.busy || div_stat.done))
		else $error("divider idle while sequencer waits on it");
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (state_q != S_IDLE || out_valid_q))
		else $error("accepted request produced no work");
	a_fault_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fault_q) |-> (kind_q == K_EXEC))
		else $error("fault on a non-execute request");
endmodule
